// File: hdl/vumb_pkg.sv
package vumb_pkg;

  localparam int unsigned SmpW   = 24;
  localparam int unsigned StW    = 32;
  localparam int unsigned PeakW  = 31;
  localparam int unsigned CoefW  = 22;
  localparam int unsigned GainW  = 16;
  localparam int unsigned LevelW = 31;
  localparam int unsigned MulBW  = 24;
  localparam int unsigned ProdW  = StW + MulBW + 1;
  localparam int unsigned NumSmp = 4;
  localparam int unsigned SelW   = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 22;

  localparam logic signed [StW-1:0] StLimit    = 32'sd335544320;
  localparam logic [LevelW:0]       LevelMax   = 32'd1342177280;
  localparam logic [CoefW-1:0]      CoefReset  = 22'd3880;
  localparam logic [GainW-1:0]      GainReset  = 16'd38610;

  localparam logic [CfgIdxW-1:0] CFG_COEF = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_GAIN = 1'b1;

  localparam logic OP_GROUP = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_LOAD,
    DP_DIFF_FAST,
    DP_MUL_FAST,
    DP_ACC_FAST,
    DP_DIFF_SLOW,
    DP_MUL_SLOW,
    DP_ACC_SLOW,
    DP_PEAK,
    DP_MUL_READ,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t          op;
    logic [SelW-1:0] sel;
  } dp_cmd_t;

endpackage

// File: hdl/vumb_if.sv
interface vumb_in_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic signed [vumb_pkg::SmpW-1:0] sample_a;
  logic signed [vumb_pkg::SmpW-1:0] sample_b;
  logic signed [vumb_pkg::SmpW-1:0] sample_c;
  logic signed [vumb_pkg::SmpW-1:0] sample_d;

  modport source (output valid, op, sample_a, sample_b, sample_c, sample_d, input ready);
  modport sink (input valid, op, sample_a, sample_b, sample_c, sample_d, output ready);
endinterface

interface vumb_out_if;
  logic                        valid;
  logic                        ready;
  logic [vumb_pkg::LevelW-1:0] level;

  modport source (output valid, level, input ready);
  modport sink (input valid, level, output ready);
endinterface

// File: hdl/vumb_ctrl.sv
module vumb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output vumb_pkg::dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_DIFF,
    S_MUL,
    S_ACC,
    S_SDIFF,
    S_SMUL,
    S_SACC,
    S_PEAK,
    S_RMUL,
    S_ROUT
  } state_t;

  state_t                      state_r;
  logic [vumb_pkg::SelW-1:0]   sel_r;
  logic                        out_valid_r;
  logic                        out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd.sel = sel_r;
    unique case (state_r)
      S_IDLE:  cmd.op = (in_valid && in_ready) ? vumb_pkg::DP_CAPTURE : vumb_pkg::DP_NOP;
      S_LOAD:  cmd.op = vumb_pkg::DP_LOAD;
      S_DIFF:  cmd.op = vumb_pkg::DP_DIFF_FAST;
      S_MUL:   cmd.op = vumb_pkg::DP_MUL_FAST;
      S_ACC:   cmd.op = vumb_pkg::DP_ACC_FAST;
      S_SDIFF: cmd.op = vumb_pkg::DP_DIFF_SLOW;
      S_SMUL:  cmd.op = vumb_pkg::DP_MUL_SLOW;
      S_SACC:  cmd.op = vumb_pkg::DP_ACC_SLOW;
      S_PEAK:  cmd.op = vumb_pkg::DP_PEAK;
      S_RMUL:  cmd.op = vumb_pkg::DP_MUL_READ;
      S_ROUT:  cmd.op = out_free ? vumb_pkg::DP_OUT : vumb_pkg::DP_NOP;
      default: cmd.op = vumb_pkg::DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ((state_r == S_ROUT) && out_free) || (out_valid_r && !out_ready);
      unique case (state_r)
        S_IDLE: begin
          sel_r <= '0;
          if (in_valid) begin
            state_r <= (in_op == vumb_pkg::OP_READ) ? S_RMUL : S_LOAD;
          end
        end
        S_LOAD:  state_r <= S_DIFF;
        S_DIFF:  state_r <= S_MUL;
        S_MUL:   state_r <= S_ACC;
        S_ACC: begin
          sel_r <= sel_r + 1'b1;
          state_r <= (sel_r == vumb_pkg::SelW'(vumb_pkg::NumSmp - 1)) ? S_SDIFF : S_DIFF;
        end
        S_SDIFF: state_r <= S_SMUL;
        S_SMUL:  state_r <= S_SACC;
        S_SACC:  state_r <= S_PEAK;
        S_PEAK:  state_r <= S_IDLE;
        S_RMUL:  state_r <= S_ROUT;
        S_ROUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/vumb_dp.sv
module vumb_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  vumb_pkg::dp_cmd_t                   cmd,
  input  logic                                cfg_we,
  input  logic [vumb_pkg::CfgIdxW-1:0]        cfg_idx,
  input  logic [vumb_pkg::CfgDataW-1:0]       cfg_data,
  input  logic signed [vumb_pkg::SmpW-1:0]    sample_a,
  input  logic signed [vumb_pkg::SmpW-1:0]    sample_b,
  input  logic signed [vumb_pkg::SmpW-1:0]    sample_c,
  input  logic signed [vumb_pkg::SmpW-1:0]    sample_d,
  output logic [vumb_pkg::LevelW-1:0]         level
);

  logic [vumb_pkg::CoefW-1:0]               coef_r;
  logic [vumb_pkg::GainW-1:0]               gain_r;
  logic signed [vumb_pkg::StW-1:0]          z1_r;
  logic signed [vumb_pkg::StW-1:0]          z2_r;
  logic signed [vumb_pkg::StW-1:0]          half_r;
  logic signed [vumb_pkg::StW-1:0]          diff_r;
  logic signed [vumb_pkg::ProdW-1:0]        prod_r;
  logic [vumb_pkg::PeakW-1:0]               peak_r;
  logic                                     restart_r;
  logic [vumb_pkg::LevelW-1:0]              level_r;
  logic signed [vumb_pkg::SmpW-1:0]         smp_r [vumb_pkg::NumSmp];

  logic signed [vumb_pkg::SmpW-1:0]         smp_cur;
  logic signed [vumb_pkg::StW+1:0]          rect;
  logic signed [vumb_pkg::StW+1:0]          diff_fast;
  logic signed [vumb_pkg::StW-1:0]          z1_clamp;
  logic signed [vumb_pkg::StW-1:0]          z2_clamp;
  logic signed [vumb_pkg::StW-1:0]          mul_a;
  logic [vumb_pkg::MulBW-1:0]               mul_b;
  logic signed [vumb_pkg::StW-1:0]          prod_q24;
  logic [vumb_pkg::LevelW+1:0]              lvl_raw;

  function automatic logic signed [vumb_pkg::StW-1:0] clamp20(
    input logic signed [vumb_pkg::StW-1:0] v
  );
    logic signed [vumb_pkg::StW-1:0] r;
    r = v;
    if (v > vumb_pkg::StLimit) begin
      r = vumb_pkg::StLimit;
    end else if (v < -vumb_pkg::StLimit) begin
      r = -vumb_pkg::StLimit;
    end
    return r;
  endfunction

  assign smp_cur   = smp_r[cmd.sel];
  assign rect      = (smp_cur < 0) ? -((vumb_pkg::StW+2)'(smp_cur) <<< 1)
                                   : ((vumb_pkg::StW+2)'(smp_cur) <<< 1);
  assign diff_fast = rect - (vumb_pkg::StW+2)'(half_r) - (vumb_pkg::StW+2)'(z1_r);
  assign z1_clamp  = clamp20(z1_r);
  assign z2_clamp  = clamp20(z2_r);
  assign prod_q24  = prod_r[vumb_pkg::StW+23:24];
  assign lvl_raw   = prod_r[vumb_pkg::LevelW+15:14];
  assign level     = level_r;

  always_comb begin
    unique case (cmd.op)
      vumb_pkg::DP_MUL_FAST: begin
        mul_a = diff_r;
        mul_b = vumb_pkg::MulBW'(coef_r);
      end
      vumb_pkg::DP_MUL_SLOW: begin
        mul_a = diff_r;
        mul_b = {coef_r, 2'b00};
      end
      default: begin
        mul_a = {1'b0, peak_r};
        mul_b = vumb_pkg::MulBW'(gain_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r    <= vumb_pkg::CoefReset;
      gain_r    <= vumb_pkg::GainReset;
      z1_r      <= '0;
      z2_r      <= '0;
      peak_r    <= '0;
      restart_r <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          vumb_pkg::CFG_COEF: coef_r <= cfg_data;
          vumb_pkg::CFG_GAIN: gain_r <= cfg_data[vumb_pkg::GainW-1:0];
          default: ;
        endcase
      end
      unique case (cmd.op)
        vumb_pkg::DP_LOAD: begin
          z1_r      <= z1_clamp;
          z2_r      <= z2_clamp;
          half_r    <= z2_clamp >>> 1;
          restart_r <= 1'b0;
          if (restart_r) begin
            peak_r <= '0;
          end
        end
        vumb_pkg::DP_DIFF_FAST: diff_r <= diff_fast[vumb_pkg::StW-1:0];
        vumb_pkg::DP_ACC_FAST:  z1_r <= z1_r + prod_q24;
        vumb_pkg::DP_DIFF_SLOW: diff_r <= z1_r - z2_r;
        vumb_pkg::DP_ACC_SLOW:  z2_r <= z2_r + prod_q24;
        vumb_pkg::DP_PEAK: begin
          if (z2_r > $signed({1'b0, peak_r})) begin
            peak_r <= z2_r[vumb_pkg::PeakW-1:0];
          end
        end
        vumb_pkg::DP_OUT: begin
          restart_r <= 1'b1;
          level_r   <= (lvl_raw > (vumb_pkg::LevelW+2)'(vumb_pkg::LevelMax))
                       ? vumb_pkg::LevelMax[vumb_pkg::LevelW-1:0]
                       : lvl_raw[vumb_pkg::LevelW-1:0];
        end
        vumb_pkg::DP_MUL_FAST, vumb_pkg::DP_MUL_SLOW, vumb_pkg::DP_MUL_READ: begin
          prod_r <= mul_a * $signed({1'b0, mul_b});
        end
        vumb_pkg::DP_CAPTURE: begin
          smp_r[0] <= sample_a;
          smp_r[1] <= sample_b;
          smp_r[2] <= sample_c;
          smp_r[3] <= sample_d;
        end
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/vu_meter_ballistics.sv
// Group transaction: from acceptance back to idle the controller steps through load, four
// samples of diff/multiply/accumulate on the shared multiplier, slow update and peak.
// Read transaction: gain multiply, then the level is registered for output; the next
// acceptance waits while an earlier level is still held in the output register.
// Reset (synchronous, rst_n low): states and peak cleared, restart armed,
// coef = 3880, gain = 38610, no result pending.
module vu_meter_ballistics (
  input  logic                              clk,
  input  logic                              rst_n,
  vumb_in_if.sink                           in_if,
  vumb_out_if.source                        out_if,
  input  logic                              cfg_we,
  input  logic [vumb_pkg::CfgIdxW-1:0]      cfg_idx,
  input  logic [vumb_pkg::CfgDataW-1:0]     cfg_data
);

  vumb_pkg::dp_cmd_t cmd;

  vumb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_op     (in_if.op),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  vumb_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .sample_a (in_if.sample_a),
    .sample_b (in_if.sample_b),
    .sample_c (in_if.sample_c),
    .sample_d (in_if.sample_d),
    .level    (out_if.level)
  );

endmodule

// File: dv/tb_vu_meter_ballistics.sv
module tb_vu_meter_ballistics;
  timeunit 1ns;
  timeprecision 1ps;

  import vumb_pkg::*;

  localparam int NumPhases = 6;
  localparam int PhaseItems = 280;
  localparam int SettleCycles = 30;

  typedef struct packed {
    logic                         op;
    logic [NumSmp-1:0][SmpW-1:0]  smp;
  } vu_item_t;

  class vu_level_model;
    int unsigned       coef_r;
    int unsigned       gain_r;
    longint            fast_st;
    longint            slow_st;
    longint            peak_st;
    bit                restart;
    logic [LevelW-1:0] pending_levels[$];
    int                errors;
    int                checked;

    function new();
      coef_r  = CoefReset;
      gain_r  = GainReset;
      fast_st = 0;
      slow_st = 0;
      peak_st = 0;
      restart = 1'b1;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CFG_COEF) begin
        coef_r = data[CoefW-1:0];
      end else begin
        gain_r = data[GainW-1:0];
      end
    endfunction

    function longint clamp_st(longint v);
      longint lim;
      lim = StLimit;
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function void take_item(vu_item_t it);
      longint z1, z2, w, m, half, s, t, lvl;
      if (it.op == OP_READ) begin
        lvl = (longint'(gain_r) * peak_st) >>> 14;
        if (lvl > longint'(LevelMax)) lvl = LevelMax;
        pending_levels.push_back(lvl[LevelW-1:0]);
        restart = 1'b1;
        return;
      end
      z1 = clamp_st(fast_st);
      z2 = clamp_st(slow_st);
      w = coef_r;
      m = restart ? 0 : peak_st;
      half = z2 >>> 1;
      restart = 1'b0;
      for (int i = 0; i < NumSmp; i++) begin
        s = $signed(it.smp[i]);
        if (s < 0) s = -s;
        t = 2 * s - half;
        z1 = z1 + ((w * (t - z1)) >>> 24);
      end
      z2 = z2 + ((4 * w * (z1 - z2)) >>> 24);
      if (z2 > m) m = z2;
      fast_st = z1;
      slow_st = z2;
      peak_st = m & 64'h7FFF_FFFF;
    endfunction

    function void check_level(logic [LevelW-1:0] got);
      logic [LevelW-1:0] want;
      if (pending_levels.size() == 0) begin
        $error("level: unexpected result %0d", got);
        errors++;
        return;
      end
      want = pending_levels.pop_front();
      checked++;
      if (got !== want) begin
        $error("level mismatch: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  bit idle_on;
  int n_group;
  int n_read;
  int n_settings;
  vu_level_model lvl_model;

  vumb_in_if  in_if ();
  vumb_out_if out_if ();

  vu_meter_ballistics uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_if   (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      lvl_model.check_level(out_if.level);
    end
  end

  function automatic vu_item_t mk_item(logic op, logic [SmpW-1:0] a, logic [SmpW-1:0] b,
                                       logic [SmpW-1:0] c, logic [SmpW-1:0] d);
    vu_item_t it;
    it.op = op;
    it.smp[0] = a;
    it.smp[1] = b;
    it.smp[2] = c;
    it.smp[3] = d;
    return it;
  endfunction

  function automatic logic [SmpW-1:0] rand_sample(int unsigned loudness);
    logic [SmpW-1:0] v;
    int unsigned mag;
    case ($urandom_range(0, 5))
      0: v = 24'h7F_FFFF;
      1: v = 24'h80_0000;
      2: v = 24'($signed($urandom_range(0, 2)) - 1);
      3: v = 24'($urandom());
      default: begin
        mag = $urandom_range(0, loudness);
        v = $urandom_range(0, 1) ? 24'(mag) : 24'(-$signed(mag));
      end
    endcase
    return v;
  endfunction

  function automatic vu_item_t rand_item(int unsigned loudness);
    vu_item_t it;
    it.op = ($urandom_range(0, 4) == 0) ? OP_READ : OP_GROUP;
    for (int i = 0; i < NumSmp; i++) it.smp[i] = rand_sample(loudness);
    return it;
  endfunction

  task automatic send_item(vu_item_t it);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.op       <= it.op;
    in_if.sample_a <= it.smp[0];
    in_if.sample_b <= it.smp[1];
    in_if.sample_c <= it.smp[2];
    in_if.sample_d <= it.smp[3];
    do @(posedge clk); while (in_if.ready !== 1'b1);
    lvl_model.take_item(it);
    if (it.op == OP_READ) n_read++;
    else n_group++;
  endtask

  task automatic drain_levels();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (lvl_model.pending_levels.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain_levels();
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    lvl_model.set_reg(idx, data);
  endtask

  task automatic apply_setting(int unsigned coef_v, int unsigned gain_v);
    settle();
    write_reg(CFG_COEF, CfgDataW'(coef_v));
    write_reg(CFG_GAIN, CfgDataW'(gain_v));
    n_settings++;
  endtask

  task automatic run_directed();
    send_item(mk_item(OP_READ, '0, '0, '0, '0));
    send_item(mk_item(OP_GROUP, 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF));
    send_item(mk_item(OP_GROUP, 24'h80_0000, 24'h80_0000, 24'h80_0000, 24'h80_0000));
    send_item(mk_item(OP_READ, '0, '0, '0, '0));
    send_item(mk_item(OP_READ, 24'hFF_FFFF, 24'h7F_FFFF, 24'h80_0000, 24'h00_0001));
    send_item(mk_item(OP_GROUP, '0, '0, '0, '0));
    send_item(mk_item(OP_GROUP, 24'h7F_FFFF, 24'h80_0000, '0, 24'hFF_FFFF));
    send_item(mk_item(OP_READ, '0, '0, '0, '0));
    send_item(mk_item(OP_GROUP, 24'h00_0001, 24'hFF_FFFF, 24'h7F_FFFF, 24'h80_0000));
    send_item(mk_item(OP_READ, '0, '0, '0, '0));
    apply_setting(22'h3F_FFFF, 16'hFFFF);
    for (int i = 0; i < 6; i++) begin
      send_item(mk_item(OP_GROUP, 24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF, 24'h80_0000));
    end
    send_item(mk_item(OP_READ, '0, '0, '0, '0));
    send_item(mk_item(OP_READ, '0, '0, '0, '0));
    for (int i = 0; i < 3; i++) send_item(mk_item(OP_GROUP, '0, '0, '0, '0));
    send_item(mk_item(OP_READ, '0, '0, '0, '0));
    send_item(mk_item(OP_GROUP, 24'h00_0100, 24'hFF_FF00, 24'h00_0100, 24'hFF_FF00));
    send_item(mk_item(OP_READ, '0, '0, '0, '0));
  endtask

  task automatic run_random(int n);
    int unsigned loudness;
    loudness = 24'h7F_FFFF;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 31) == 0) loudness = 1 << $urandom_range(4, 23);
      if ($urandom_range(0, 149) == 0) drain_levels();
      send_item(rand_item(loudness - 1));
    end
  endtask

  initial begin
    int unsigned coef_plan [NumPhases];
    int unsigned gain_plan [NumPhases];
    lvl_model = new();
    idle_on = 1'b1;
    n_group = 0;
    n_read = 0;
    n_settings = 1;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= CFG_COEF;
    cfg_data       <= '0;
    in_if.valid    <= 1'b0;
    in_if.op       <= OP_GROUP;
    in_if.sample_a <= '0;
    in_if.sample_b <= '0;
    in_if.sample_c <= '0;
    in_if.sample_d <= '0;
    coef_plan = '{22'h3F_FFFF, 0, 1, $urandom_range(0, 22'h3F_FFFF), 22'h1F_FFFF, CoefReset};
    gain_plan = '{16'hFFFF, 0, 1, $urandom_range(0, 16'hFFFF), 16'h4000, GainReset};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int p = 0; p < NumPhases; p++) begin
      apply_setting(coef_plan[p], gain_plan[p]);
      if (p == NumPhases - 1) idle_on = 1'b0;
      run_random(PhaseItems);
    end
    settle();
    $display("Summary: %0d group and %0d read transactions over %0d register settings",
             n_group, n_read, n_settings);
    $display("Summary: %0d levels compared, %0d mismatches",
             lvl_model.checked, lvl_model.errors);
    if (lvl_model.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
